// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the DFA minimizer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check an implication property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hdl/dsm_pkg.sv -----
// Shared types and constants of the DFA state minimizer.
// No dependencies; used by the configuration interface, the register bank and the top module.
package dsm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SYMBOLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_STATE  = 2'd2;

    localparam logic [6:0] NUM_STATES_RST  = 7'd1;
    localparam logic [4:0] NUM_SYMBOLS_RST = 5'd2;
    localparam logic [5:0] INIT_STATE_RST  = 6'd0;

    typedef struct packed {
        logic [6:0] num_states;
        logic [4:0] num_symbols;
        logic [5:0] init_state;
    } cfg_t;

endpackage

// ----- hdl/dsm_ifs.sv -----
// Valid/ready channel interfaces of the DFA state minimizer.
// Depends on dsm_pkg for the configuration port widths.
interface dsm_item_if;
    logic       valid;
    logic       ready;
    logic [5:0] src_state;
    logic [3:0] symbol;
    logic [5:0] dst_state;
    logic       is_final;
    logic       last;
    modport source (output valid, src_state, symbol, dst_state, is_final, last,
                    input ready);
    modport sink (input valid, src_state, symbol, dst_state, is_final, last,
                  output ready);
endinterface

interface dsm_result_if;
    logic       valid;
    logic       ready;
    logic [5:0] state_index;
    logic [5:0] group_index;
    logic [6:0] group_count;
    logic [5:0] start_group;
    logic       group_is_final;
    logic       end_of_run;
    modport source (output valid, state_index, group_index, group_count, start_group,
                    group_is_final, end_of_run, input ready);
    modport sink (input valid, state_index, group_index, group_count, start_group,
                  group_is_final, end_of_run, output ready);
endinterface

interface dsm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dsm_pkg::CFG_IDX_W-1:0]  index;
    logic [dsm_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/dsm_ram.sv -----
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module dsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]                       rd_data_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]                       rd_data_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end
endmodule

// ----- hdl/dsm_cfg_regs.sv -----
// Configuration register bank of the DFA state minimizer.
// Depends on dsm_pkg and the dsm_cfg_if interface.
module dsm_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    dsm_cfg_if.sink        cfg,
    output dsm_pkg::cfg_t  regs
);
    dsm_pkg::cfg_t regs_reg;
    dsm_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                dsm_pkg::REG_NUM_STATES:  regs_next.num_states  = cfg.data;
                dsm_pkg::REG_NUM_SYMBOLS: regs_next.num_symbols = cfg.data[4:0];
                dsm_pkg::REG_INIT_STATE:  regs_next.init_state  = cfg.data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.num_states  <= dsm_pkg::NUM_STATES_RST;
            regs_reg.num_symbols <= dsm_pkg::NUM_SYMBOLS_RST;
            regs_reg.init_state  <= dsm_pkg::INIT_STATE_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end
endmodule

// ----- hdl/dfa_state_minimizer_top.sv -----
// DFA state minimizer: loads transitions one per cycle, then refines groups.
// After the last item: a setup scan over the states; per round, for each group a scan
// of every state, a leader check per candidate and a compare per symbol, a write per new
// subgroup, and a copy pass; then the start group is looked up and each result is sent.
// Loading takes one transaction per cycle; input stalls until the last result.
// Reset clears control, configuration and final flags; the memories need no clear.
`include "assert_macros.svh"

module dfa_state_minimizer_top #(
    parameter int MAX_STATES  = 64,
    parameter int MAX_SYMBOLS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    dsm_item_if.sink      items,
    dsm_result_if.source  results,
    dsm_cfg_if.sink       cfg
);
    // Widths: SW indexes a state or a group, CW holds a count up to MAX_STATES.
    localparam int SW    = $clog2(MAX_STATES);
    localparam int CW    = $clog2(MAX_STATES + 1);
    localparam int KW    = $clog2(MAX_SYMBOLS + 1);
    localparam int TDEP  = MAX_STATES * MAX_SYMBOLS;
    localparam int TAW   = $clog2(TDEP);

    // Sequencer codes.
    localparam logic [4:0] S_LOAD   = 5'd0;
    localparam logic [4:0] S_ISCAN  = 5'd1;
    localparam logic [4:0] S_IWR    = 5'd2;
    localparam logic [4:0] S_RSCAN  = 5'd3;
    localparam logic [4:0] S_RCHK   = 5'd4;
    localparam logic [4:0] S_RLEAD  = 5'd5;
    localparam logic [4:0] S_RTR    = 5'd6;
    localparam logic [4:0] S_RCL    = 5'd7;
    localparam logic [4:0] S_RCMP   = 5'd8;
    localparam logic [4:0] S_RNEW   = 5'd9;
    localparam logic [4:0] S_CRD    = 5'd10;
    localparam logic [4:0] S_CWR    = 5'd11;
    localparam logic [4:0] S_OSTART = 5'd12;
    localparam logic [4:0] S_OSG    = 5'd13;
    localparam logic [4:0] S_ORD    = 5'd14;
    localparam logic [4:0] S_OLAT   = 5'd15;
    localparam logic [4:0] S_OWAIT  = 5'd16;

    dsm_pkg::cfg_t cfg_q;

    dsm_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_q)
    );

    // Control and working registers.
    logic [4:0]            state_reg, state_next;
    logic [SW-1:0]         s_reg, s_next;
    logic [SW-1:0]         g_reg, g_next;
    logic [CW-1:0]         j_reg, j_next;
    logic [CW-1:0]         first_reg, first_next;
    logic [CW-1:0]         ng_reg, ng_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [KW-1:0]         sym_reg, sym_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [SW-1:0]         lead_reg, lead_next;
    logic                  anyf_reg, anyf_next;
    logic                  anynf_reg, anynf_next;
    logic [SW-1:0]         sg_reg, sg_next;
    logic                  dl_ok_reg, dl_ok_next;
    logic                  ds_ok_reg, ds_ok_next;
    logic [MAX_STATES-1:0] flags_reg, flags_next;
    logic                  ovalid_reg, ovalid_next;
    logic [5:0]            oidx_reg, oidx_next;
    logic [5:0]            ogrp_reg, ogrp_next;
    logic                  ofin_reg, ofin_next;
    logic                  oend_reg, oend_next;

    // Memory ports.
    logic                  t_we;
    logic [TAW-1:0]        t_waddr, t_raddr_a, t_raddr_b;
    logic [5:0]            t_rdata_a, t_rdata_b;
    logic                  c_we;
    logic [SW-1:0]         c_waddr, c_wdata, c_raddr_a, c_raddr_b, c_rdata_a, c_rdata_b;
    logic                  x_we;
    logic [SW-1:0]         x_waddr, x_wdata, x_raddr, x_rdata;
    logic                  l_we;
    logic [SW-1:0]         l_waddr, l_wdata, l_raddr, l_rdata;

    logic                  item_acc, res_acc, last_s;
    logic [31:0]           n_clamp, k_clamp, ta_w, ta_a, ta_b;
    logic [CW-1:0]         ng_adv;
    logic                  cls_eq;

    dsm_ram #(.WIDTH(6), .DEPTH(TDEP)) u_trans (
        .clk (clk), .wr_en (t_we), .wr_addr (t_waddr), .wr_data (items.dst_state),
        .rd_addr_a (t_raddr_a), .rd_data_a (t_rdata_a),
        .rd_addr_b (t_raddr_b), .rd_data_b (t_rdata_b)
    );
    dsm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_cur (
        .clk (clk), .wr_en (c_we), .wr_addr (c_waddr), .wr_data (c_wdata),
        .rd_addr_a (c_raddr_a), .rd_data_a (c_rdata_a),
        .rd_addr_b (c_raddr_b), .rd_data_b (c_rdata_b)
    );
    dsm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_next (
        .clk (clk), .wr_en (x_we), .wr_addr (x_waddr), .wr_data (x_wdata),
        .rd_addr_a (x_raddr), .rd_data_a (x_rdata),
        .rd_addr_b ('0), .rd_data_b ()
    );
    dsm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_lead (
        .clk (clk), .wr_en (l_we), .wr_addr (l_waddr), .wr_data (l_wdata),
        .rd_addr_a (l_raddr), .rd_data_a (l_rdata),
        .rd_addr_b ('0), .rd_data_b ()
    );

    // Handshakes: items load only while idle; results come from one output register.
    assign items.ready            = (state_reg == S_LOAD);
    assign item_acc               = items.valid && items.ready;
    assign res_acc                = ovalid_reg && results.ready;
    assign results.valid          = ovalid_reg;
    assign results.state_index    = oidx_reg;
    assign results.group_index    = ogrp_reg;
    assign results.group_count    = 7'(cnt_reg);
    assign results.start_group    = 6'(sg_reg);
    assign results.group_is_final = ofin_reg;
    assign results.end_of_run     = oend_reg;

    assign last_s = ((CW'(s_reg) + CW'(1)) == n_reg);

    // Transition store addresses: state times the symbol stride plus symbol.
    assign ta_w = 32'(items.src_state) * MAX_SYMBOLS + 32'(items.symbol);
    assign ta_a = 32'(lead_reg) * MAX_SYMBOLS + 32'(sym_reg);
    assign ta_b = 32'(s_reg) * MAX_SYMBOLS + 32'(sym_reg);

    assign t_we      = item_acc && (32'(items.src_state) < MAX_STATES)
                                && (32'(items.symbol) < MAX_SYMBOLS);
    assign t_waddr   = ta_w[TAW-1:0];
    assign t_raddr_a = ta_a[TAW-1:0];
    assign t_raddr_b = ta_b[TAW-1:0];

    // Saturate the configured counts, raising zero to one, when a run starts.
    assign n_clamp = (cfg_q.num_states == 7'd0) ? 32'd1 :
                     (32'(cfg_q.num_states) > MAX_STATES) ? 32'(MAX_STATES) :
                     32'(cfg_q.num_states);
    assign k_clamp = (cfg_q.num_symbols == 5'd0) ? 32'd1 :
                     (32'(cfg_q.num_symbols) > MAX_SYMBOLS) ? 32'(MAX_SYMBOLS) :
                     32'(cfg_q.num_symbols);

    // Targets outside the states in use form one class distinct from every group.
    assign cls_eq = (dl_ok_reg == ds_ok_reg) && (!dl_ok_reg || (c_rdata_a == c_rdata_b));

    always_comb
    begin
        state_next  = state_reg;
        s_next      = s_reg;
        g_next      = g_reg;
        j_next      = j_reg;
        first_next  = first_reg;
        ng_next     = ng_reg;
        cnt_next    = cnt_reg;
        sym_next    = sym_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        lead_next   = lead_reg;
        anyf_next   = anyf_reg;
        anynf_next  = anynf_reg;
        sg_next     = sg_reg;
        dl_ok_next  = dl_ok_reg;
        ds_ok_next  = ds_ok_reg;
        flags_next  = flags_reg;
        ovalid_next = ovalid_reg;
        oidx_next   = oidx_reg;
        ogrp_next   = ogrp_reg;
        ofin_next   = ofin_reg;
        oend_next   = oend_reg;
        ng_adv      = ng_reg;

        c_we      = 1'b0;
        c_waddr   = s_reg;
        c_wdata   = '0;
        c_raddr_a = s_reg;
        c_raddr_b = s_reg;
        x_we      = 1'b0;
        x_waddr   = s_reg;
        x_wdata   = '0;
        x_raddr   = s_reg;
        l_we      = 1'b0;
        l_waddr   = ng_reg[SW-1:0];
        l_wdata   = s_reg;
        l_raddr   = first_reg[SW-1:0];

        unique case (state_reg)
            S_LOAD:
            begin
                if (item_acc)
                begin
                    if ((32'(items.src_state) < MAX_STATES) && items.is_final)
                    begin
                        flags_next[SW'(items.src_state)] = 1'b1;
                    end
                    if (items.last)
                    begin
                        n_next     = CW'(n_clamp);
                        k_next     = KW'(k_clamp);
                        s_next     = '0;
                        ng_next    = '0;
                        anyf_next  = 1'b0;
                        anynf_next = 1'b0;
                        state_next = S_ISCAN;
                    end
                end
            end
            S_ISCAN:
            begin
                // Find which of the two start groups are populated.
                anyf_next  = anyf_reg || flags_reg[s_reg];
                anynf_next = anynf_reg || !flags_reg[s_reg];
                if (last_s)
                begin
                    s_next     = '0;
                    state_next = S_IWR;
                end
                else
                begin
                    s_next = s_reg + SW'(1);
                end
            end
            S_IWR:
            begin
                c_we    = 1'b1;
                c_wdata = (flags_reg[s_reg] && anynf_reg) ? SW'(1) : '0;
                if (last_s)
                begin
                    cnt_next   = CW'(anyf_reg) + CW'(anynf_reg);
                    ng_next    = '0;
                    first_next = '0;
                    g_next     = '0;
                    s_next     = '0;
                    state_next = S_RSCAN;
                end
                else
                begin
                    s_next = s_reg + SW'(1);
                end
            end
            S_RSCAN:
            begin
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                if (c_rdata_a == g_reg)
                begin
                    j_next = first_reg;
                    if (first_reg < ng_reg)
                    begin
                        state_next = S_RLEAD;
                    end
                    else
                    begin
                        state_next = S_RNEW;
                    end
                end
                else
                begin
                    state_next = S_RSCAN;
                end
            end
            S_RLEAD:
            begin
                lead_next  = l_rdata;
                sym_next   = '0;
                state_next = S_RTR;
            end
            S_RTR:
            begin
                state_next = S_RCL;
            end
            S_RCL:
            begin
                c_raddr_a  = SW'(t_rdata_a);
                c_raddr_b  = SW'(t_rdata_b);
                dl_ok_next = (32'(t_rdata_a) < 32'(n_reg));
                ds_ok_next = (32'(t_rdata_b) < 32'(n_reg));
                state_next = S_RCMP;
            end
            S_RCMP:
            begin
                if (!cls_eq)
                begin
                    // Try the next leader of this group, or open a subgroup.
                    j_next  = j_reg + CW'(1);
                    l_raddr = SW'(j_reg + CW'(1));
                    if ((j_reg + CW'(1)) < ng_reg)
                    begin
                        state_next = S_RLEAD;
                    end
                    else
                    begin
                        state_next = S_RNEW;
                    end
                end
                else if ((KW'(sym_reg) + KW'(1)) < k_reg)
                begin
                    sym_next   = sym_reg + KW'(1);
                    state_next = S_RTR;
                end
                else
                begin
                    x_we    = 1'b1;
                    x_wdata = j_reg[SW-1:0];
                end
            end
            S_RNEW:
            begin
                l_we    = 1'b1;
                x_we    = 1'b1;
                x_wdata = ng_reg[SW-1:0];
                ng_adv  = ng_reg + CW'(1);
                ng_next = ng_adv;
            end
            S_CRD:
            begin
                state_next = S_CWR;
            end
            S_CWR:
            begin
                c_we    = 1'b1;
                c_wdata = x_rdata;
                if (last_s)
                begin
                    s_next = '0;
                    if (ng_reg == cnt_reg)
                    begin
                        state_next = S_OSTART;
                    end
                    else
                    begin
                        cnt_next   = ng_reg;
                        ng_next    = '0;
                        first_next = '0;
                        g_next     = '0;
                        state_next = S_RSCAN;
                    end
                end
                else
                begin
                    s_next     = s_reg + SW'(1);
                    state_next = S_CRD;
                end
            end
            S_OSTART:
            begin
                c_raddr_a  = SW'(cfg_q.init_state);
                state_next = S_OSG;
            end
            S_OSG:
            begin
                sg_next    = (32'(cfg_q.init_state) < 32'(n_reg)) ? c_rdata_a : '0;
                s_next     = '0;
                state_next = S_ORD;
            end
            S_ORD:
            begin
                state_next = S_OLAT;
            end
            S_OLAT:
            begin
                // Groups never mix accepting and rejecting states.
                ovalid_next = 1'b1;
                oidx_next   = 6'(s_reg);
                ogrp_next   = 6'(c_rdata_a);
                ofin_next   = flags_reg[s_reg];
                oend_next   = last_s;
                state_next  = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (res_acc)
                begin
                    ovalid_next = 1'b0;
                    if (last_s)
                    begin
                        flags_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        s_next     = s_reg + SW'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // Advance the scan once a state has been placed in a subgroup or skipped as outside the group.
        if ((state_reg == S_RNEW) || (state_reg == S_RCMP && cls_eq
                && !((KW'(sym_reg) + KW'(1)) < k_reg))
                || (state_reg == S_RCHK && c_rdata_a != g_reg))
        begin
            if (last_s)
            begin
                s_next     = '0;
                g_next     = g_reg + SW'(1);
                first_next = ng_adv;
                if ((CW'(g_reg) + CW'(1)) == cnt_reg)
                begin
                    state_next = S_CRD;
                end
                else
                begin
                    state_next = S_RSCAN;
                end
            end
            else
            begin
                s_next     = s_reg + SW'(1);
                state_next = S_RSCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            flags_reg  <= '0;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
            ng_reg     <= '0;
            n_reg      <= CW'(1);
            s_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            flags_reg  <= flags_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
            ng_reg     <= ng_next;
            n_reg      <= n_next;
            s_reg      <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg     <= g_next;
        j_reg     <= j_next;
        first_reg <= first_next;
        sym_reg   <= sym_next;
        k_reg     <= k_next;
        lead_reg  <= lead_next;
        anyf_reg  <= anyf_next;
        anynf_reg <= anynf_next;
        sg_reg    <= sg_next;
        dl_ok_reg <= dl_ok_next;
        ds_ok_reg <= ds_ok_next;
        oidx_reg  <= oidx_next;
        ogrp_reg  <= ogrp_next;
        ofin_reg  <= ofin_next;
        oend_reg  <= oend_next;
    end

    // Never take new transitions while results are pending.
    `ASSERT_NEVER(a_no_load_while_out, clk, rst_n, results.valid && items.ready)
    // After the last result the block returns to loading.
    `ASSERT_PROP(a_back_to_load, clk, rst_n, (res_acc && results.end_of_run) |=> items.ready)
    // The subgroup count cannot exceed the number of states.
    `ASSERT_NEVER(a_ng_bound, clk, rst_n, ng_reg > n_reg)
    // The run ends on the highest state index.
    `ASSERT_PROP(a_end_index, clk, rst_n,
        (results.valid && results.end_of_run) |-> (CW'(results.state_index) + CW'(1) == n_reg))
endmodule
